### rtl/i2cte_pkg.sv
// shared types and constants for the i2c target byte engine
// no dependencies; imported by i2c_target_byte_engine
`default_nettype none

package i2cte_pkg;

    // default ring depths
    localparam int DEF_SEND_DEPTH = 16;
    localparam int DEF_RECV_DEPTH = 16;

    // shifter bit counts
    localparam logic [3:0] BITS_BYTE = 4'd8;
    localparam logic [3:0] BITS_ACK  = 4'd1;

    // item commands
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_SHIFT = 2'd1,
        CMD_PUSH  = 2'd2,
        CMD_POP   = 2'd3
    } t_cmd;

    // protocol phases
    typedef enum logic [2:0] {
        PH_CHECK_ADDR  = 3'd0,
        PH_SEND        = 3'd1,
        PH_REQ_REPLY   = 3'd2,
        PH_CHECK_REPLY = 3'd3,
        PH_REQ_DATA    = 3'd4,
        PH_GET_DATA    = 3'd5
    } t_phase;

endpackage

`default_nettype wire

### rtl/i2c_target_byte_engine.sv
// i2c target byte engine: protocol phase tracking plus transmit and receive rings
// depends on i2cte_pkg
`default_nettype none

// Each input beat is one event (start, shift complete, host push, host pop): the phase,
// ring pointers and shifter set-up update at the accepting edge and the result beat is
// ready in the next cycle. One beat per cycle is taken as long as the result register is
// free or being drained, so the result register's stall sets the rate. Each ring is an
// internal memory with one write port and one registered read port; a ring holds at most
// depth minus one bytes. The own address register is written through its own port,
// which is always ready; the user is to write it only while the block is idle, which
// the block itself does not enforce.
module i2c_target_byte_engine
    import i2cte_pkg::*;
#(
    parameter int SEND_DEPTH = DEF_SEND_DEPTH,
    parameter int RECV_DEPTH = DEF_RECV_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [6:0] i_cfg_data,
    // input channel
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [1:0] i_cmd,
    input  wire  [7:0] i_bus_data,
    input  wire  [7:0] i_host_data,
    // output channel
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic       o_sda_drive,
    output logic [7:0] o_drive_byte,
    output logic [3:0] o_shift_bits,
    output logic       o_bus_active,
    output logic [2:0] o_phase,
    output logic       o_tx_accepted,
    output logic [7:0] o_rx_data,
    output logic       o_rx_valid,
    output logic       o_rx_available,
    output logic       o_rx_overrun
);

    localparam int SPW = $clog2(SEND_DEPTH);
    localparam int RPW = $clog2(RECV_DEPTH);
    localparam logic [SPW-1:0] SEND_LAST = SPW'(SEND_DEPTH - 1);
    localparam logic [RPW-1:0] RECV_LAST = RPW'(RECV_DEPTH - 1);

    // state
    logic [6:0]     r_own_addr;
    t_phase         r_phase, n_phase;
    logic           r_engaged, n_engaged;
    logic [SPW-1:0] r_send_head, n_send_head, r_send_tail, n_send_tail;
    logic [RPW-1:0] r_recv_head, n_recv_head, r_recv_tail, n_recv_tail;
    logic           r_cur_sda, n_cur_sda;
    logic           r_cur_ring, n_cur_ring;
    logic [3:0]     r_cur_bits, n_cur_bits;
    logic           r_tx_ok, n_tx_ok;
    logic           r_rx_v, n_rx_v;
    logic           r_ovr, n_ovr;
    logic           r_out_valid;

    // rings and their read registers
    logic [7:0]     r_send_mem [SEND_DEPTH];
    logic [7:0]     r_recv_mem [RECV_DEPTH];
    logic [7:0]     r_send_rd;
    logic [7:0]     r_recv_rd;

    logic           w_acc;
    t_cmd           w_cmd;
    logic [SPW-1:0] w_send_head_inc, w_send_tail_inc;
    logic [RPW-1:0] w_recv_head_inc, w_recv_tail_inc;
    logic           w_send_avail, w_send_room, w_recv_avail, w_recv_room;
    logic           w_addr_match;
    logic           w_send_wr, w_send_rd, w_recv_wr, w_recv_rd;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_acc       = i_in_valid & ~o_in_stall;
    assign w_cmd       = t_cmd'(i_cmd);

    // ring pointer arithmetic, wrapping at the depth
    assign w_send_head_inc = (r_send_head == SEND_LAST) ? '0 : r_send_head + 1'b1;
    assign w_send_tail_inc = (r_send_tail == SEND_LAST) ? '0 : r_send_tail + 1'b1;
    assign w_recv_head_inc = (r_recv_head == RECV_LAST) ? '0 : r_recv_head + 1'b1;
    assign w_recv_tail_inc = (r_recv_tail == RECV_LAST) ? '0 : r_recv_tail + 1'b1;
    assign w_send_avail    = r_send_head != r_send_tail;
    assign w_send_room     = w_send_head_inc != r_send_tail;
    assign w_recv_avail    = r_recv_head != r_recv_tail;
    assign w_recv_room     = w_recv_head_inc != r_recv_tail;

    // general call or own address
    assign w_addr_match = (i_bus_data == 8'h00) || (i_bus_data[7:1] == r_own_addr);

    // next phase and engagement
    always_comb begin
        n_phase   = r_phase;
        n_engaged = r_engaged;
        case (w_cmd)
            CMD_START: begin
                n_engaged = 1'b1;
                n_phase   = PH_CHECK_ADDR;
            end
            CMD_SHIFT: begin
                if (r_engaged) begin
                    case (r_phase)
                        PH_CHECK_ADDR: begin
                            if (w_addr_match) begin
                                n_phase = i_bus_data[0] ? PH_SEND : PH_REQ_DATA;
                            end else begin
                                n_engaged = 1'b0;
                            end
                        end
                        PH_SEND: begin
                            if (w_send_avail) begin
                                n_phase = PH_REQ_REPLY;
                            end else begin
                                n_engaged = 1'b0;
                                n_phase   = PH_CHECK_ADDR;
                            end
                        end
                        PH_CHECK_REPLY: begin
                            if (i_bus_data == 8'h00 && w_send_avail) begin
                                n_phase = PH_REQ_REPLY;
                            end else begin
                                n_engaged = 1'b0;
                                n_phase   = PH_CHECK_ADDR;
                            end
                        end
                        PH_REQ_REPLY: n_phase = PH_CHECK_REPLY;
                        PH_REQ_DATA:  n_phase = PH_GET_DATA;
                        PH_GET_DATA:  n_phase = PH_REQ_DATA;
                        default: begin
                            n_engaged = 1'b0;
                            n_phase   = PH_CHECK_ADDR;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // shifter set-up, ring actions and per-beat flags
    always_comb begin
        n_cur_sda   = r_cur_sda;
        n_cur_ring  = r_cur_ring;
        n_cur_bits  = r_cur_bits;
        n_send_head = r_send_head;
        n_send_tail = r_send_tail;
        n_recv_head = r_recv_head;
        n_recv_tail = r_recv_tail;
        n_tx_ok     = 1'b0;
        n_rx_v      = 1'b0;
        n_ovr       = 1'b0;
        w_send_wr   = 1'b0;
        w_send_rd   = 1'b0;
        w_recv_wr   = 1'b0;
        w_recv_rd   = 1'b0;
        case (w_cmd)
            CMD_START: begin
                n_cur_sda  = 1'b0;
                n_cur_ring = 1'b0;
                n_cur_bits = BITS_BYTE;
            end
            CMD_SHIFT: begin
                if (r_engaged) begin
                    // idle set-up unless a case below overrides it
                    n_cur_sda  = 1'b0;
                    n_cur_ring = 1'b0;
                    n_cur_bits = BITS_BYTE;
                    case (r_phase)
                        PH_CHECK_ADDR: begin
                            if (w_addr_match) begin
                                n_cur_sda  = 1'b1;
                                n_cur_bits = BITS_ACK;
                            end
                        end
                        PH_SEND, PH_CHECK_REPLY: begin
                            if (w_send_avail &&
                                (r_phase == PH_SEND || i_bus_data == 8'h00)) begin
                                n_send_tail = w_send_tail_inc;
                                w_send_rd   = 1'b1;
                                n_cur_sda   = 1'b1;
                                n_cur_ring  = 1'b1;
                            end
                        end
                        PH_REQ_REPLY: begin
                            n_cur_bits = BITS_ACK;
                        end
                        PH_REQ_DATA: begin
                        end
                        PH_GET_DATA: begin
                            if (w_recv_room) begin
                                n_recv_head = w_recv_head_inc;
                                w_recv_wr   = 1'b1;
                            end else begin
                                n_ovr = 1'b1;
                            end
                            n_cur_sda  = 1'b1;
                            n_cur_bits = BITS_ACK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CMD_PUSH: begin
                if (w_send_room) begin
                    n_send_head = w_send_head_inc;
                    w_send_wr   = 1'b1;
                    n_tx_ok     = 1'b1;
                end
            end
            CMD_POP: begin
                if (w_recv_avail) begin
                    n_recv_tail = w_recv_tail_inc;
                    w_recv_rd   = 1'b1;
                    n_rx_v      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own_addr <= i_cfg_data;
        end
    end

    // control state and result flags, updated per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CHECK_ADDR;
            r_engaged   <= 1'b0;
            r_send_head <= '0;
            r_send_tail <= '0;
            r_recv_head <= '0;
            r_recv_tail <= '0;
            r_cur_sda   <= 1'b0;
            r_cur_ring  <= 1'b0;
            r_cur_bits  <= BITS_BYTE;
            r_tx_ok     <= 1'b0;
            r_rx_v      <= 1'b0;
            r_ovr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_phase     <= n_phase;
                r_engaged   <= n_engaged;
                r_send_head <= n_send_head;
                r_send_tail <= n_send_tail;
                r_recv_head <= n_recv_head;
                r_recv_tail <= n_recv_tail;
                r_cur_sda   <= n_cur_sda;
                r_cur_ring  <= n_cur_ring;
                r_cur_bits  <= n_cur_bits;
                r_tx_ok     <= n_tx_ok;
                r_rx_v      <= n_rx_v;
                r_ovr       <= n_ovr;
            end
            // result beat held until taken
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transmit ring
    always_ff @(posedge i_clk) begin
        if (w_acc && w_send_wr) begin
            r_send_mem[w_send_head_inc] <= i_host_data;
        end
        if (w_acc && w_send_rd) begin
            r_send_rd <= r_send_mem[w_send_tail_inc];
        end
    end

    // receive ring
    always_ff @(posedge i_clk) begin
        if (w_acc && w_recv_wr) begin
            r_recv_mem[w_recv_head_inc] <= i_bus_data;
        end
        if (w_acc && w_recv_rd) begin
            r_recv_rd <= r_recv_mem[w_recv_tail_inc];
        end
    end

    // result beat
    assign o_out_valid    = r_out_valid;
    assign o_sda_drive    = r_cur_sda;
    assign o_drive_byte   = r_cur_ring ? r_send_rd : 8'h00;
    assign o_shift_bits   = r_cur_bits;
    assign o_bus_active   = r_engaged;
    assign o_phase        = r_phase;
    assign o_tx_accepted  = r_tx_ok;
    assign o_rx_data      = r_rx_v ? r_recv_rd : 8'h00;
    assign o_rx_valid     = r_rx_v;
    assign o_rx_available = r_recv_head != r_recv_tail;
    assign o_rx_overrun   = r_ovr;

endmodule

`default_nettype wire
